@@ rtl/core/ktmp_pkg.sv @@
package ktmp_pkg;

  // Widths fixed by the stream fields and the configuration register.
  localparam int PRICE_IN_W = 16;
  localparam int PROFIT_W   = 32;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0]    TRADES_RESET = 5'd2;
  localparam logic [PROFIT_W-1:0] PROFIT_MAX   = {PROFIT_W{1'b1}};

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic upd;  // a price transfer is taken this cycle
    logic clr;  // the transfer starts a new series
  } cell_ctl_t;

endpackage

@@ rtl/core/ktmp_cell.sv @@
module ktmp_cell
  import ktmp_pkg::*;
#(
  parameter int PRICE_WIDTH = 16
) (
  input  logic                        clk,
  input  cell_ctl_t                   ctl,
  input  logic [PROFIT_W-1:0]         below_i,    // overall best of the cell one trade lower
  input  logic [PRICE_WIDTH-1:0]      gain_i,     // positive part of the price step
  input  logic signed [PRICE_WIDTH:0] delta_i,    // signed price step
  output logic [PROFIT_W-1:0]         overall_o
);

  localparam int SUM_W = PROFIT_W + 2;

  logic [PROFIT_W-1:0]    ends_r, ends_nxt;
  logic [PROFIT_W-1:0]    overall_r, overall_nxt;
  logic signed [SUM_W-1:0] sell_today, hold_on, best;

  always_comb begin
    // Either open a fresh trade on top of the lower count, or extend today's trade.
    sell_today = $signed({2'b00, below_i}) + $signed({{(SUM_W-PRICE_WIDTH){1'b0}}, gain_i});
    hold_on    = $signed({2'b00, ends_r}) + SUM_W'(delta_i);
    best       = (sell_today > hold_on) ? sell_today : hold_on;
    // The first choice is never negative, so only the upper bound needs clamping.
    if (best[SUM_W-1:PROFIT_W] != 2'b00) begin
      ends_nxt = PROFIT_MAX;
    end else begin
      ends_nxt = best[PROFIT_W-1:0];
    end
    overall_nxt = (ends_nxt > overall_r) ? ends_nxt : overall_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      if (ctl.clr) begin
        ends_r    <= '0;
        overall_r <= '0;
      end else begin
        ends_r    <= ends_nxt;
        overall_r <= overall_nxt;
      end
    end
  end

  assign overall_o = overall_r;

endmodule

@@ rtl/core/k_trade_max_profit_dp.sv @@
// Best profit from a stream of prices with at most max_trades buy-sell
// transactions. Each input transfer carries one price; in_tuser set starts a
// new series (the very first transfer after reset also starts one). A row of
// TRADE_CAPACITY identical cells, one per trade count, keeps the best profit
// whose last trade ends today and the best profit so far; every cell updates
// in the cycle a price is taken, using its lower neighbor's value from the
// previous price. Every input transfer yields exactly one output transfer with
// the best profit for the configured trade count (zero for the first price of
// a series, zero for a count of zero, the top cell for counts above capacity);
// profits saturate at all ones. Throughput is one price per clock while the
// output side keeps taking results. A result passes through the cell update
// and then the registered trade-count select that feeds out_tdata.
// max_trades resets to two and must only be written while the block is idle.
module k_trade_max_profit_dp
  import ktmp_pkg::*;
#(
  parameter int TRADE_CAPACITY = 16,
  parameter int PRICE_WIDTH    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: max_trades
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,   // [4:0] max_trades
  // Price stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PRICE_IN_W-1:0] in_tdata,    // [15:0] price
  input  logic                  in_tuser,    // [0] first_day
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PROFIT_W-1:0]   out_tdata    // [31:0] best_profit
);

  localparam int IDX_W = (TRADE_CAPACITY > 1) ? $clog2(TRADE_CAPACITY) : 1;
  localparam int KX_W  = 7;  // holds any capacity up to 64 and any register value

  logic [CFG_W-1:0]       max_trades_r;
  logic [PRICE_WIDTH-1:0] prev_price_r;
  logic                   have_prev_r;
  logic                   pend_r;
  logic                   out_valid_r;
  logic [PROFIT_W-1:0]    out_data_r;

  logic                   in_xfer;
  logic                   move_ok;
  logic [31:0]            price_ext;
  logic [PRICE_WIDTH-1:0] price_w;
  logic signed [PRICE_WIDTH:0] delta;
  logic [PRICE_WIDTH-1:0] gain;
  cell_ctl_t              ctl;
  logic [PROFIT_W-1:0]    overall_w [TRADE_CAPACITY];
  logic [KX_W-1:0]        k_ext;
  logic [KX_W-1:0]        k_sel;
  logic [PROFIT_W-1:0]    result;

  // The result of the previous price can leave the select stage in the same
  // cycle a new price updates the cells, since the select reads the cells
  // before that edge.
  assign move_ok   = !out_valid_r || out_tready;
  assign in_tready = !pend_r || move_ok;
  assign in_xfer   = in_tvalid && in_tready;

  assign price_ext = {{(32-PRICE_IN_W){1'b0}}, in_tdata};
  assign price_w   = price_ext[PRICE_WIDTH-1:0];
  assign delta     = $signed({1'b0, price_w}) - $signed({1'b0, prev_price_r});
  assign gain      = delta[PRICE_WIDTH] ? '0 : delta[PRICE_WIDTH-1:0];

  assign ctl.upd = in_xfer;
  assign ctl.clr = in_tuser || !have_prev_r;

  // Cell j holds trade count j+1; the first cell sees a zero profit below it.
  for (genvar j = 0; j < TRADE_CAPACITY; j++) begin : g_cell
    logic [PROFIT_W-1:0] below;
    if (j == 0) begin : g_first
      assign below = '0;
    end else begin : g_rest
      assign below = overall_w[j-1];
    end
    ktmp_cell #(
      .PRICE_WIDTH(PRICE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .below_i  (below),
      .gain_i   (gain),
      .delta_i  (delta),
      .overall_o(overall_w[j])
    );
  end

  // Trade-count select: counts above capacity read the top cell, a count of zero gives zero.
  always_comb begin
    k_ext = {{(KX_W-CFG_W){1'b0}}, max_trades_r};
    if (k_ext > KX_W'(TRADE_CAPACITY)) begin
      k_sel = KX_W'(TRADE_CAPACITY - 1);
    end else begin
      k_sel = k_ext - 1'b1;
    end
    if (k_ext == '0) begin
      result = '0;
    end else begin
      result = overall_w[k_sel[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_trades_r <= TRADES_RESET;
      have_prev_r  <= 1'b0;
      prev_price_r <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_trades_r <= cfg_wdata;
      end
      if (in_xfer) begin
        prev_price_r <= price_w;
        have_prev_r  <= 1'b1;
      end
      if (in_xfer) begin
        pend_r <= 1'b1;
      end else if (move_ok) begin
        pend_r <= 1'b0;
      end
      if (pend_r && move_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && move_ok) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A price that starts a series leaves the lowest cell at zero profit.
  a_clear_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_tuser || !have_prev_r)) |=> (overall_w[0] == '0))
    else $error("lowest cell not cleared at the start of a series");

  // Within a series the lowest cell's best profit so far never decreases.
  a_overall_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tuser && have_prev_r) |=> (overall_w[0] >= $past(overall_w[0])))
    else $error("overall best profit decreased within a series");

  // A waiting result that cannot move blocks new prices.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("price taken while a result was stuck in the select stage");

  // Every taken price leaves a result pending in the select stage.
  a_pend_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (pend_r && have_prev_r))
    else $error("no pending result after a price transfer");
`endif

endmodule
